>>> rtl/hwde_pkg.sv
// Shared types and constants for the hashed word dictionary encoder.
// No dependencies; used by hwde_update and hashed_word_dictionary_encoder.
package hwde_pkg;

  localparam int unsigned TABLE_SIZE_DEF = 65536;
  localparam int unsigned BLOCK_WORDS    = 8;
  localparam int unsigned EPOCH_W        = 8;
  localparam logic [31:0] HASH_MULT      = 32'h9e3779b9;
  localparam logic [31:0] MIN_DEST_BYTES = 32'd38;
  localparam logic [31:0] START_BYTES    = 32'd6;
  localparam logic [31:0] MAX_OUT_RESET  = 32'd1048576;

  typedef enum logic [1:0] {
    KIND_INDEX   = 2'd0,
    KIND_LITERAL = 2'd1,
    KIND_RAW     = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK          = 2'd0,
    STAT_SMALL_INPUT = 2'd1,
    STAT_SMALL_DEST  = 2'd2,
    STAT_OVERFLOW    = 2'd3
  } status_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  vb;
    logic        tail;
    logic        first;
    logic        last;
  } item_t;

  // request in flight, tagged with the table epoch it belongs to
  typedef struct packed {
    item_t              item;
    logic [EPOCH_W-1:0] epoch;
  } stage_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] payload;
    logic [2:0]  pbytes;
    logic        done;
    logic [7:0]  ctrl;
    logic [31:0] block_total;
    logic [4:0]  tail_len;
    logic [31:0] out_total;
    status_t     status;
    logic        eos;
  } result_t;

endpackage

>>> rtl/hashed_word_dictionary_encoder.sv
// Hashed word dictionary encoder top level: hash stage, table pipeline, clear sequencer.
// Depends on hwde_pkg, hwde_ram and hwde_update.
//
// The encoder takes one 32-bit word per cycle while in_tready is high and returns one
// result per word, in order; out_tvalid is registered behind the s1, s2 and output
// stages (hash multiply registered at acceptance, table read, compare and write-back). The
// dictionary is a single RAM of TABLE_SIZE entries, read while a word sits in s1 and
// written while it sits in s2; a word that hits the entry written just before it sees that
// write through a bypass register, so back-to-back repeats need no stall. Each entry
// carries an 8-bit stream epoch, so a stream start clears the table in no time. After
// reset, and whenever a stream start finds the epoch used up (the 256th start after
// reset, then every 255th), the block sweeps
// the whole table, one entry per cycle, over all TABLE_SIZE entries (65536 by default);
// in_tready stays low for that sweep and while earlier words drain ahead of it.
// A stalled result holds the whole pipeline, so in_tready also follows out_tready.
// Write max_output_bytes through cfg_wr_en/cfg_wr_data only while no request is
// in flight.
module hashed_word_dictionary_encoder #(
  parameter int unsigned TABLE_SIZE = hwde_pkg::TABLE_SIZE_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [39:0]  in_tdata,   // data[31:0], valid_bytes[34:32], zero fill
  input  logic [1:0]   in_tuser,   // tail[0], first[1]
  input  logic         in_tlast,   // last
  output logic         out_tvalid,
  input  logic         out_tready,
  // payload[31:0], payload_bytes[34:32], block_done[35], block_control[43:36],
  // block_total[75:44], tail_length[80:76], output_total[112:81], status[114:113]
  output logic [119:0] out_tdata,
  output logic [1:0]   out_tuser,  // code_kind
  output logic         out_tlast,  // end_of_stream
  input  logic         cfg_wr_en,
  input  logic [31:0]  cfg_wr_data
);

  localparam int unsigned IDX_W   = $clog2(TABLE_SIZE);
  localparam int unsigned EPOCH_W = hwde_pkg::EPOCH_W;
  localparam int unsigned ENTRY_W = EPOCH_W + 32;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_RUN   = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t               st_r, st_nxt;
  logic [IDX_W-1:0]     clr_cnt_r;
  logic [EPOCH_W-1:0]   epoch_r;
  logic [31:0]          max_r;

  logic                 adv;
  logic                 in_acc;
  logic                 epoch_full;
  hwde_pkg::stage_t     in_stage;
  logic [63:0]          hash_prod;

  logic                 s1_v_r, s2_v_r;
  hwde_pkg::stage_t     s1_r, s2_r;
  logic [IDX_W-1:0]     s1_idx_r, s2_idx_r;

  logic                 fwd_v_r;
  logic [IDX_W-1:0]     fwd_addr_r;
  logic [ENTRY_W-1:0]   fwd_data_r;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [ENTRY_W-1:0]   ram_wdata;
  logic [ENTRY_W-1:0]   ram_rdata;
  logic [ENTRY_W-1:0]   entry;
  logic [31:0]          old_word;

  logic                 upd_wr;
  logic                 tbl_wr;
  hwde_pkg::result_t    upd_res;
  hwde_pkg::result_t    out_r;
  logic                 out_v_r;

  // ---------------- input and hash ----------------
  assign adv        = !out_v_r || out_tready;
  assign epoch_full = (epoch_r == {EPOCH_W{1'b1}});
  assign in_tready  = adv && (st_r == ST_RUN) && !(in_tuser[1] && epoch_full);
  assign in_acc     = in_tvalid && in_tready;

  assign in_stage.item.word  = in_tdata[31:0];
  assign in_stage.item.vb    = in_tdata[34:32];
  assign in_stage.item.tail  = in_tuser[0];
  assign in_stage.item.first = in_tuser[1];
  assign in_stage.item.last  = in_tlast;
  assign in_stage.epoch      = in_tuser[1] ? epoch_r + 1'b1 : epoch_r;

  assign hash_prod = 64'(in_tdata[31:0]) * 64'(hwde_pkg::HASH_MULT);

  // ---------------- clear sequencer and epoch ----------------
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_CLEAR: if (clr_cnt_r == IDX_W'(TABLE_SIZE - 1)) st_nxt = ST_RUN;
      ST_RUN:   if (in_tvalid && in_tuser[1] && epoch_full) st_nxt = ST_DRAIN;
      ST_DRAIN: if (!s1_v_r && !s2_v_r) st_nxt = ST_CLEAR;
      default:  st_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_CLEAR;
      clr_cnt_r <= '0;
      epoch_r   <= '0;
      max_r     <= hwde_pkg::MAX_OUT_RESET;
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        epoch_r   <= '0;
      end else begin
        clr_cnt_r <= '0;
        if (in_acc) begin
          epoch_r <= in_stage.epoch;
        end
      end
      if (cfg_wr_en) begin
        max_r <= cfg_wr_data;
      end
    end
  end

  // ---------------- pipeline registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      fwd_v_r <= 1'b0;
    end else begin
      if (adv) begin
        s1_v_r  <= in_acc;
        s2_v_r  <= s1_v_r;
        out_v_r <= s2_v_r;
      end
      // remember the write that lands alongside the next item's read
      if (st_r == ST_CLEAR) begin
        fwd_v_r <= 1'b0;
      end else if (adv) begin
        fwd_v_r <= tbl_wr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r       <= in_stage;
      s1_idx_r   <= hash_prod[32 +: IDX_W];
      s2_r       <= s1_r;
      s2_idx_r   <= s1_idx_r;
      fwd_addr_r <= s2_idx_r;
      fwd_data_r <= {s2_r.epoch, s2_r.item.word};
      if (s2_v_r) begin
        out_r <= upd_res;
      end
    end
  end

  // ---------------- dictionary ----------------
  assign tbl_wr    = adv && s2_v_r && upd_wr;
  assign ram_we    = (st_r == ST_CLEAR) || tbl_wr;
  assign ram_waddr = (st_r == ST_CLEAR) ? clr_cnt_r : s2_idx_r;
  assign ram_wdata = (st_r == ST_CLEAR) ? '0 : {s2_r.epoch, s2_r.item.word};

  hwde_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_SIZE)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (adv),
    .raddr (s1_idx_r),
    .rdata (ram_rdata)
  );

  assign entry    = (fwd_v_r && fwd_addr_r == s2_idx_r) ? fwd_data_r : ram_rdata;
  // an entry from an older stream reads as cleared
  assign old_word = (entry[ENTRY_W-1 -: EPOCH_W] == s2_r.epoch) ? entry[31:0] : 32'd0;

  hwde_update #(
    .IDX_W (IDX_W)
  ) u_update (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv && s2_v_r),
    .item      (s2_r.item),
    .idx       (s2_idx_r),
    .old_word  (old_word),
    .max_bytes (max_r),
    .wr_req    (upd_wr),
    .res       (upd_res)
  );

  // ---------------- result channel ----------------
  assign out_tvalid = out_v_r;
  assign out_tdata  = {5'd0, out_r.status, out_r.out_total, out_r.tail_len,
                       out_r.block_total, out_r.ctrl, out_r.done, out_r.pbytes,
                       out_r.payload};
  assign out_tuser  = out_r.kind;
  assign out_tlast  = out_r.eos;

endmodule

>>> rtl/hwde_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// A read of the address being written returns the old contents. No dependencies.
module hwde_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/hwde_update.sv
// Match decision and stream bookkeeping: block position, control byte, counters, status.
// Depends on hwde_pkg.
module hwde_update #(
  parameter int unsigned IDX_W = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  hwde_pkg::item_t      item,
  input  logic [IDX_W-1:0]     idx,
  input  logic [31:0]          old_word,
  input  logic [31:0]          max_bytes,
  output logic                 wr_req,
  output hwde_pkg::result_t    res
);

  logic [2:0]          wp_r, wp_nxt;
  logic [7:0]          acc_r, acc_nxt;
  logic [31:0]         bc_r, bc_nxt;
  logic [31:0]         byc_r, byc_nxt;
  logic [4:0]          tc_r, tc_nxt;
  hwde_pkg::status_t   err_r, err_nxt;

  logic [2:0]          nb;
  logic [2:0]          add_n;
  logic [5:0]          tsum;
  logic [32:0]         bsum;
  logic [31:0]         byc_base;
  logic                last_slot;

  always_comb begin
    // first word restarts the stream before it is handled
    wp_nxt   = item.first ? 3'd0 : wp_r;
    acc_nxt  = item.first ? 8'd0 : acc_r;
    bc_nxt   = item.first ? 32'd0 : bc_r;
    byc_base = item.first ? hwde_pkg::START_BYTES : byc_r;
    tc_nxt   = item.first ? 5'd0 : tc_r;
    if (item.first) begin
      err_nxt = (!item.tail && max_bytes < hwde_pkg::MIN_DEST_BYTES) ?
                hwde_pkg::STAT_SMALL_DEST : hwde_pkg::STAT_OK;
    end else begin
      err_nxt = err_r;
    end

    res.kind    = hwde_pkg::KIND_NONE;
    res.payload = 32'd0;
    res.pbytes  = 3'd0;
    res.done    = 1'b0;
    wr_req      = 1'b0;
    add_n       = 3'd0;
    nb          = (item.vb > 3'd4) ? 3'd4 : item.vb;
    tsum        = {1'b0, tc_nxt} + {3'd0, nb};
    last_slot   = (wp_nxt == 3'(hwde_pkg::BLOCK_WORDS - 1));

    if (err_nxt == hwde_pkg::STAT_OK) begin
      if (item.tail) begin
        if (bc_nxt == 32'd0) begin
          err_nxt = hwde_pkg::STAT_SMALL_INPUT;
        end else begin
          case (nb)
            3'd0:    res.payload = 32'd0;
            3'd1:    res.payload = {24'd0, item.word[7:0]};
            3'd2:    res.payload = {16'd0, item.word[15:0]};
            3'd3:    res.payload = {8'd0, item.word[23:0]};
            default: res.payload = item.word;
          endcase
          res.kind   = hwde_pkg::KIND_RAW;
          res.pbytes = nb;
          tc_nxt     = tsum[5] ? 5'd31 : tsum[4:0];
          add_n      = nb;
        end
      end else if (wp_nxt == 3'd0 && byc_base >= max_bytes) begin
        err_nxt = hwde_pkg::STAT_OVERFLOW;
      end else begin
        wr_req = 1'b1;
        if (old_word == item.word) begin
          acc_nxt     = acc_nxt | (8'd1 << wp_nxt);
          res.kind    = hwde_pkg::KIND_INDEX;
          res.payload = 32'(idx);
          res.pbytes  = 3'd2;
        end else begin
          res.kind    = hwde_pkg::KIND_LITERAL;
          res.payload = item.word;
          res.pbytes  = 3'd4;
        end
        // closing a block also adds its control byte
        add_n = res.pbytes + {2'd0, last_slot};
        if (last_slot) begin
          res.done = 1'b1;
          bc_nxt   = bc_nxt + 32'd1;
        end
        wp_nxt = wp_nxt + 3'd1;
      end
    end

    bsum    = {1'b0, byc_base} + {30'd0, add_n};
    byc_nxt = bsum[32] ? 32'hFFFF_FFFF : bsum[31:0];

    res.ctrl        = acc_nxt;
    res.block_total = bc_nxt;
    res.tail_len    = tc_nxt;
    res.out_total   = byc_nxt;
    res.status      = err_nxt;
    res.eos         = item.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 3'd0;
      acc_r <= 8'd0;
      bc_r  <= 32'd0;
      byc_r <= hwde_pkg::START_BYTES;
      tc_r  <= 5'd0;
      err_r <= hwde_pkg::STAT_OK;
    end else if (en) begin
      wp_r  <= wp_nxt;
      acc_r <= res.done ? 8'd0 : acc_nxt;
      bc_r  <= bc_nxt;
      byc_r <= byc_nxt;
      tc_r  <= tc_nxt;
      err_r <= err_nxt;
    end
  end

endmodule
